@@ sv/rlbe_pkg.sv @@
package rlbe_pkg;

    // Widths of the configuration port.
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    // Largest number of button slots the register layout packs.
    localparam int SLOT_MAX = 4;

    // Samples this close to the last accepted one, or closer, are dropped.
    localparam logic [31:0] DEBOUNCE_MS = 32'd10;

    typedef logic [1:0] ev_code_t;

    localparam ev_code_t EV_DOWN  = 2'd0;
    localparam ev_code_t EV_HOLD  = 2'd1;
    localparam ev_code_t EV_CLICK = 2'd2;
    localparam ev_code_t EV_UP    = 2'd3;

    typedef logic [2:0] reg_index_t;

    localparam reg_index_t REG_BUTTON_ENABLE     = 3'd0;
    localparam reg_index_t REG_BUTTON_CENTERS    = 3'd1;
    localparam reg_index_t REG_BUTTON_TOLERANCES = 3'd2;
    localparam reg_index_t REG_HOLD_START_TIMES  = 3'd3;
    localparam reg_index_t REG_HOLD_INTERVALS    = 3'd4;
    localparam reg_index_t REG_CLICK_LIMITS      = 3'd5;

endpackage

@@ sv/resistor_ladder_button_events_core.sv @@
// Resistor-ladder keypad event detector. Each input transfer carries one 12-bit
// converter reading of the shared button ladder and a wrapping millisecond
// timestamp. A sample that arrives 10 ms or less after the last accepted sample
// is dropped without effect. Otherwise every enabled slot checks whether the
// reading lies inside its center plus or minus tolerance and reports down on a
// new press, hold once the hold start delay and the repeat interval have passed,
// and click or up on release depending on the click limit. Each event leaves as
// one output transfer carrying the slot, the event code and a flag on the final
// event of the sample; events of one sample leave in ascending slot order. A
// sample is taken into an input register, evaluated combinationally, and its
// events are parked in a small event buffer that drains one transfer per cycle
// while m_ready is high. A new sample is taken while the previous sample's final
// event leaves, so samples with no events stream at one per cycle. The output
// buffer drain, one event per cycle while m_ready is high, is what sets the rate.
// Configuration goes through the APB port with 64-bit data, register i at byte
// address 8*i, and must only be written while the block is idle.
module resistor_ladder_button_events_core #(
    parameter int NUM_BUTTONS = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rlbe_pkg::PADDR_W-1:0] paddr,
    input  logic [rlbe_pkg::PDATA_W-1:0] pwdata,
    output logic [rlbe_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [11:0]                 s_adc_sample,
    input  logic [31:0]                 s_now_ms,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_button_index,
    output logic [1:0]                  m_event_code,
    output logic                        m_last_event
);
    import rlbe_pkg::*;

    // Configuration registers, kept at their full packed widths.
    logic [3:0]  enable_reg;
    logic [47:0] centers_reg;
    logic [47:0] tolerances_reg;
    logic [63:0] hold_start_reg;
    logic [63:0] hold_interval_reg;
    logic [63:0] click_limit_reg;

    // Per-slot button state.
    logic [NUM_BUTTONS-1:0] pressed_reg;
    logic [NUM_BUTTONS-1:0] pressed_next;
    logic [31:0]            press_time_reg [NUM_BUTTONS];
    logic [31:0]            press_time_next [NUM_BUTTONS];
    logic [31:0]            hold_time_reg [NUM_BUTTONS];
    logic [31:0]            hold_time_next [NUM_BUTTONS];
    logic [31:0]            last_time_reg;

    // Input register.
    logic                   in_valid_reg;
    logic [11:0]            sample_reg;
    logic [31:0]            now_reg;

    // Event buffer: one pending bit and one code per slot.
    logic [NUM_BUTTONS-1:0] ev_mask_reg;
    logic [NUM_BUTTONS-1:0] ev_mask_next;
    ev_code_t               ev_code_reg [NUM_BUTTONS];
    ev_code_t               ev_code_next [NUM_BUTTONS];

    logic                   cfg_write;
    reg_index_t             cfg_index;
    logic                   drop;
    logic                   buf_free;
    logic                   advance;
    logic [NUM_BUTTONS-1:0] ev_low_bit;
    logic [1:0]             ev_sel;
    ev_code_t               ev_out_code;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[PADDR_W-1:3]);

    // The configuration registers are control state: reset clears them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg        <= '0;
            centers_reg       <= '0;
            tolerances_reg    <= '0;
            hold_start_reg    <= '0;
            hold_interval_reg <= '0;
            click_limit_reg   <= '0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_BUTTON_ENABLE:     enable_reg        <= pwdata[3:0];
                REG_BUTTON_CENTERS:    centers_reg       <= pwdata[47:0];
                REG_BUTTON_TOLERANCES: tolerances_reg    <= pwdata[47:0];
                REG_HOLD_START_TIMES:  hold_start_reg    <= pwdata;
                REG_HOLD_INTERVALS:    hold_interval_reg <= pwdata;
                REG_CLICK_LIMITS:      click_limit_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_BUTTON_ENABLE:     prdata = {60'd0, enable_reg};
            REG_BUTTON_CENTERS:    prdata = {16'd0, centers_reg};
            REG_BUTTON_TOLERANCES: prdata = {16'd0, tolerances_reg};
            REG_HOLD_START_TIMES:  prdata = hold_start_reg;
            REG_HOLD_INTERVALS:    prdata = hold_interval_reg;
            REG_CLICK_LIMITS:      prdata = click_limit_reg;
            default:               prdata = '0;
        endcase
    end

    // The buffer can take a new set of events when it is empty or when its
    // final pending event leaves in this cycle.
    assign buf_free = (ev_mask_reg == '0) ||
                      (m_ready && ((ev_mask_reg & ~ev_low_bit) == '0));
    assign advance  = in_valid_reg && buf_free;
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            sample_reg <= s_adc_sample;
            now_reg    <= s_now_ms;
        end
    end

    // One pass over the registered sample. Every slot is evaluated in
    // parallel; the buffer keeps slot order for the output.
    assign drop = (now_reg - last_time_reg) <= DEBOUNCE_MS;

    always_comb begin
        logic [11:0]        center;
        logic [11:0]        tol;
        logic signed [13:0] win_lo;
        logic [12:0]        win_hi;
        logic               in_win;
        logic [31:0]        since_press;
        logic [31:0]        since_hold;

        ev_mask_next = '0;
        pressed_next = pressed_reg;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            center      = centers_reg[12*i +: 12];
            tol         = tolerances_reg[12*i +: 12];
            // The window may reach below zero; compare as plain integers.
            win_lo      = $signed({2'b00, center}) - $signed({2'b00, tol});
            win_hi      = {1'b0, center} + {1'b0, tol};
            in_win      = ($signed({2'b00, sample_reg}) >= win_lo) &&
                          ({1'b0, sample_reg} <= win_hi);
            since_press = now_reg - press_time_reg[i];
            since_hold  = now_reg - hold_time_reg[i];

            ev_code_next[i]    = EV_DOWN;
            press_time_next[i] = press_time_reg[i];
            hold_time_next[i]  = hold_time_reg[i];

            if (!drop) begin
                if (!enable_reg[i]) begin
                    // A disabled slot forgets its press without an event.
                    pressed_next[i] = 1'b0;
                end else if (in_win) begin
                    if (!pressed_reg[i]) begin
                        ev_mask_next[i]    = 1'b1;
                        ev_code_next[i]    = EV_DOWN;
                        press_time_next[i] = now_reg;
                    end else if (since_press >= {16'd0, hold_start_reg[16*i +: 16]} &&
                                 since_hold >= {16'd0, hold_interval_reg[16*i +: 16]}) begin
                        ev_mask_next[i]   = 1'b1;
                        ev_code_next[i]   = EV_HOLD;
                        hold_time_next[i] = now_reg;
                    end
                    pressed_next[i] = 1'b1;
                end else begin
                    if (pressed_reg[i]) begin
                        ev_mask_next[i] = 1'b1;
                        ev_code_next[i] =
                            (since_press <= {16'd0, click_limit_reg[16*i +: 16]}) ?
                            EV_CLICK : EV_UP;
                    end
                    pressed_next[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg   <= '0;
            last_time_reg <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                press_time_reg[i] <= '0;
                hold_time_reg[i]  <= '0;
            end
        end else if (advance && !drop) begin
            pressed_reg   <= pressed_next;
            last_time_reg <= now_reg;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                press_time_reg[i] <= press_time_next[i];
                hold_time_reg[i]  <= hold_time_next[i];
            end
        end
    end

    // Lowest pending slot goes out first.
    always_comb begin
        ev_low_bit  = '0;
        ev_sel      = '0;
        ev_out_code = EV_DOWN;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (ev_mask_reg[i]) begin
                ev_low_bit    = '0;
                ev_low_bit[i] = 1'b1;
                ev_sel        = 2'(i);
                ev_out_code   = ev_code_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_mask_reg <= '0;
        end else if (advance) begin
            ev_mask_reg <= ev_mask_next;
        end else if (m_valid && m_ready) begin
            ev_mask_reg <= ev_mask_reg & ~ev_low_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                ev_code_reg[i] <= ev_code_next[i];
            end
        end
    end

    assign m_valid        = (ev_mask_reg != '0);
    assign m_button_index = ev_sel;
    assign m_event_code   = ev_out_code;
    assign m_last_event   = ((ev_mask_reg & ~ev_low_bit) == '0);

endmodule

@@ sv/rlbe_checker.sv @@
module rlbe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       pready,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_button_index,
    input logic [1:0] m_event_code,
    input logic       m_last_event
);
    import rlbe_pkg::*;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_button_index) &&
            $stable(m_event_code) && $stable(m_last_event))
        else $error("stalled result changed");

    // A sample's events are delivered without gaps until the final one.
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_event |=> m_valid)
        else $error("event burst broke off before its final event");

    // Slots within one burst leave in ascending order.
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_event |=> m_button_index > $past(m_button_index))
        else $error("events left out of slot order");

    // With nothing waiting at the output, a new sample is always taken.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready && pready)
        else $error("input stalled with empty output");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind resistor_ladder_button_events_core rlbe_checker u_rlbe_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .pready         (pready),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_button_index (m_button_index),
    .m_event_code   (m_event_code),
    .m_last_event   (m_last_event)
);
